// File: rtl/core/vmbm_pkg.sv
// Shared types, codes and helpers for the video mode best-match block.
`default_nettype none

package vmbm_pkg;

	// Input word codes
	typedef logic [1:0] op_t;
	localparam op_t OP_RECORD = 2'd0;
	localparam op_t OP_END    = 2'd1;
	localparam op_t OP_FAIL   = 2'd2;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_TARGET_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_TARGET_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_TARGET_DEPTH  = 2'd2;
	localparam int unsigned CFG_DATA_W = 15;

	// Fixed modes and reset targets
	localparam logic [15:0] START_MODE   = 16'h0013;
	localparam logic [15:0] MONO_MODE    = 16'h0011;
	localparam logic [31:0] START_PIXELS = 32'd64000;
	localparam logic [7:0]  START_DEPTH  = 8'd8;
	localparam int unsigned LFB_BIT      = 7;
	localparam logic [7:0]  LAYOUT_PACKED = 8'd4;
	localparam logic [7:0]  LAYOUT_DIRECT = 8'd6;
	localparam logic [14:0] RST_WIDTH  = 15'd640;
	localparam logic [14:0] RST_HEIGHT = 15'd480;
	localparam logic [7:0]  RST_DEPTH  = 8'd8;
	localparam logic [14:0] MONO_WIDTH  = 15'd640;
	localparam logic [14:0] MONO_HEIGHT = 15'd480;
	localparam logic [7:0]  MONO_DEPTH  = 8'd1;

	typedef struct packed {
		op_t         op;
		logic [15:0] mode_number;
		logic        query_ok;
		logic [15:0] mode_attributes;
		logic [7:0]  memory_layout;
		logic [15:0] mode_width;
		logic [15:0] mode_height;
		logic [7:0]  mode_depth;
		logic [15:0] buffer_low;
		logic [15:0] buffer_high;
	} rec_word_t;

	typedef struct packed {
		logic [15:0] chosen_mode;
		logic [15:0] frame_low;
		logic [15:0] frame_high;
	} res_word_t;

	// Depth distance; a mode shallower than wanted counts double
	function automatic logic [8:0] depth_gap(input logic [7:0] have, input logic [7:0] want);
		logic [7:0] diff;
		begin
			if (have >= want) begin
				diff = have - want;
				depth_gap = {1'b0, diff};
			end else begin
				diff = want - have;
				depth_gap = {diff, 1'b0};
			end
		end
	endfunction

	function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
		begin
			abs_gap = (a >= b) ? (a - b) : (b - a);
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/vmbm_if.sv
// Handshake channels of the video mode best-match block.
`default_nettype none

interface vmbm_rec_if;
	logic              valid;
	logic              ready;
	vmbm_pkg::rec_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vmbm_res_if;
	logic              valid;
	logic              ready;
	vmbm_pkg::res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vmbm_cfg_if;
	logic                                valid;
	logic                                ready;
	vmbm_pkg::cfg_idx_t                  index;
	logic [vmbm_pkg::CFG_DATA_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/core/video_mode_best_match.sv
// Video mode best-match: picks the listed display mode closest to a target size and depth.
//
// Channels: records (sink) takes one word per mode record, an end-of-list word
// or a controller-failure word; result (source) gives the chosen mode and its
// frame buffer words; cfg (sink, always ready) writes target width, height and
// depth; the user must use it only while no record is in flight (not enforced).
// Throughput: one word per cycle while the stages have room; a stalled result
// can hold them. An accepted word passes the input stage, then the decision
// stage, and its result (if any) is registered in the result register. The
// search state holds the running best; the next decision-stage word sees it.
// The area product of each record is formed by one 16x16 multiplier between
// the input stage and the decision stage.
// When the receiver stalls, the result register holds its word and the input
// and decision stages still fill, so up to two more words are taken; words
// that give no result keep flowing.
// Reset clears all stages, ends any search and loads targets 640x480x8.
`default_nettype none

module video_mode_best_match (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vmbm_rec_if.sink   records,
	vmbm_res_if.source result,
	vmbm_cfg_if.sink   cfg
);
	import vmbm_pkg::*;

	// Configuration and derived target values
	logic [14:0] target_width_q;
	logic [14:0] target_height_q;
	logic [7:0]  target_depth_q;
	logic [29:0] target_area_q;

	// Input stage
	logic      valid_s1;
	rec_word_t word_s1;

	// Decision stage
	logic        valid_s2;
	op_t         op_s2;
	logic [15:0] mode_s2;
	logic [15:0] lo_s2;
	logic [15:0] hi_s2;
	logic [31:0] prod_s2;
	logic        usable_s2;
	logic        exact_s2;
	logic [8:0]  dgap_s2;

	// Search state
	logic        searching_q;
	logic        answered_q;
	logic [15:0] best_mode_q;
	logic [31:0] best_pgap_q;
	logic [8:0]  best_dgap_q;
	logic [15:0] best_lo_q;
	logic [15:0] best_hi_q;

	// Result register
	logic      out_valid_q;
	res_word_t out_word_q;

	// Combinational
	logic        out_free;
	logic        s2_fire;
	logic        s2_free;
	logic        s1_move;
	logic        accept;
	logic        usable_c;
	logic        exact_c;
	logic        mono;
	logic [31:0] start_pgap;
	logic [8:0]  start_dgap;
	logic        cur_answered;
	logic [15:0] cur_mode;
	logic [31:0] cur_pgap;
	logic [8:0]  cur_dgap;
	logic [15:0] cur_lo;
	logic [15:0] cur_hi;
	logic [31:0] pgap;
	logic        better;
	logic        emit;
	res_word_t   emit_word;
	logic        nxt_searching;
	logic        nxt_answered;
	logic [15:0] nxt_mode;
	logic [31:0] nxt_pgap;
	logic [8:0]  nxt_dgap;
	logic [15:0] nxt_lo;
	logic [15:0] nxt_hi;

	// Flow control: a stage moves on when the one after it has room
	assign out_free = !out_valid_q || result.ready;
	assign s2_fire  = valid_s2 && (!emit || out_free);
	assign s2_free  = !valid_s2 || s2_fire;
	assign s1_move  = valid_s1 && s2_free;
	assign accept   = records.valid && records.ready;

	assign records.ready = !valid_s1 || s2_free;
	assign cfg.ready     = 1'b1;
	assign result.valid  = out_valid_q;
	assign result.data   = out_word_q;

	// Record screening and exact-match check for the input stage word
	assign usable_c = word_s1.query_ok && word_s1.mode_attributes[LFB_BIT] &&
		(word_s1.memory_layout == LAYOUT_PACKED || word_s1.memory_layout == LAYOUT_DIRECT);
	assign exact_c = (word_s1.mode_width == {1'b0, target_width_q}) &&
		(word_s1.mode_height == {1'b0, target_height_q}) &&
		(word_s1.mode_depth == target_depth_q);

	assign mono = (target_width_q == MONO_WIDTH) && (target_height_q == MONO_HEIGHT) &&
		(target_depth_q == MONO_DEPTH);

	// Starting gaps of a new search, from the current targets
	assign start_pgap = abs_gap(START_PIXELS, {2'b00, target_area_q});
	assign start_dgap = depth_gap(START_DEPTH, target_depth_q);

	// Running best, or the starting best when no search is open
	assign cur_answered = searching_q && answered_q;
	assign cur_mode     = searching_q ? best_mode_q : START_MODE;
	assign cur_pgap     = searching_q ? best_pgap_q : start_pgap;
	assign cur_dgap     = searching_q ? best_dgap_q : start_dgap;
	assign cur_lo       = searching_q ? best_lo_q : 16'd0;
	assign cur_hi       = searching_q ? best_hi_q : 16'd0;

	assign pgap   = abs_gap(prod_s2, {2'b00, target_area_q});
	assign better = (cur_pgap > pgap) || (cur_pgap == pgap && cur_dgap > dgap_s2);

	// Decision for the word in the decision stage
	always_comb begin
		emit          = 1'b0;
		emit_word     = '{chosen_mode: START_MODE, frame_low: 16'd0, frame_high: 16'd0};
		nxt_searching = searching_q;
		nxt_answered  = answered_q;
		nxt_mode      = cur_mode;
		nxt_pgap      = cur_pgap;
		nxt_dgap      = cur_dgap;
		nxt_lo        = cur_lo;
		nxt_hi        = cur_hi;
		case (op_s2)
			OP_RECORD: begin
				nxt_searching = 1'b1;
				nxt_answered  = cur_answered;
				if (!cur_answered && usable_s2) begin
					if (exact_s2) begin
						emit         = 1'b1;
						emit_word    = '{chosen_mode: mode_s2, frame_low: lo_s2,
							frame_high: hi_s2};
						nxt_answered = 1'b1;
					end else if (better) begin
						nxt_mode = mode_s2;
						nxt_pgap = pgap;
						nxt_dgap = dgap_s2;
						nxt_lo   = lo_s2;
						nxt_hi   = hi_s2;
					end
				end
			end
			OP_END: begin
				nxt_searching = 1'b0;
				nxt_answered  = 1'b0;
				emit          = !cur_answered;
				if (mono) begin
					emit_word = '{chosen_mode: MONO_MODE, frame_low: 16'd0,
						frame_high: 16'd0};
				end else begin
					emit_word = '{chosen_mode: cur_mode, frame_low: cur_lo,
						frame_high: cur_hi};
				end
			end
			OP_FAIL: begin
				nxt_searching = 1'b0;
				nxt_answered  = 1'b0;
				emit          = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control state, configuration and derived targets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_width_q  <= RST_WIDTH;
			target_height_q <= RST_HEIGHT;
			target_depth_q  <= RST_DEPTH;
			target_area_q   <= 30'(RST_WIDTH) * 30'(RST_HEIGHT);
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			searching_q     <= 1'b0;
			answered_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TARGET_WIDTH:  target_width_q  <= cfg.wdata[14:0];
					CFG_TARGET_HEIGHT: target_height_q <= cfg.wdata[14:0];
					CFG_TARGET_DEPTH:  target_depth_q  <= cfg.wdata[7:0];
					default:           target_depth_q  <= target_depth_q;
				endcase
			end
			target_area_q <= 30'(target_width_q) * 30'(target_height_q);

			if (records.ready) begin
				valid_s1 <= records.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s2_fire) begin
				searching_q <= nxt_searching;
				answered_q  <= nxt_answered;
			end
			if (s2_fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= records.data;
		end
		if (s1_move) begin
			op_s2     <= word_s1.op;
			mode_s2   <= word_s1.mode_number;
			lo_s2     <= word_s1.buffer_low;
			hi_s2     <= word_s1.buffer_high;
			prod_s2   <= 32'(word_s1.mode_width) * 32'(word_s1.mode_height);
			usable_s2 <= usable_c;
			exact_s2  <= exact_c;
			dgap_s2   <= depth_gap(word_s1.mode_depth, target_depth_q);
		end
		if (s2_fire) begin
			best_mode_q <= nxt_mode;
			best_pgap_q <= nxt_pgap;
			best_dgap_q <= nxt_dgap;
			best_lo_q   <= nxt_lo;
			best_hi_q   <= nxt_hi;
		end
		if (s2_fire && emit) begin
			out_word_q <= emit_word;
		end
	end

`ifndef SYNTHESIS
	// An exact match is only remembered inside an open search
	a_answered_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		answered_q |-> searching_q)
		else $error("answered flag set outside a search");

	// A controller failure always closes the search
	a_fail_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_fire && op_s2 == OP_FAIL) |=> !searching_q)
		else $error("search still open after controller failure");

	// Input back-pressure only when both stages are occupied
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!records.ready |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

	// A new result only follows a decision that produced one
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_fire && emit))
		else $error("result word appeared without a decision");
`endif

endmodule

`default_nettype wire
